@@ sv/vddr_pkg.sv @@
// Shared types, widths and result codes for the vertex dedup / index remap block.
`default_nettype none

package vddr_pkg;

    // Default capacity of the unique vertex ring
    localparam int unsigned MAX_VERTICES_DEF = 256;

    // Original-position map depth and field widths
    localparam int unsigned MAP_DEPTH = 256;
    localparam int unsigned IDX_W     = 8;
    localparam int unsigned CNT_W     = 9;
    localparam int unsigned FLT_W     = 32;
    localparam int unsigned N_FIELDS  = 8;

    // Item kinds
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_INDEX  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_NOT_LOADED = 2'd2;

    // One vertex, pos_x in the lowest bits
    typedef struct packed {
        logic [FLT_W-1:0] tex_v;
        logic [FLT_W-1:0] tex_u;
        logic [FLT_W-1:0] nor_z;
        logic [FLT_W-1:0] nor_y;
        logic [FLT_W-1:0] nor_x;
        logic [FLT_W-1:0] pos_z;
        logic [FLT_W-1:0] pos_y;
        logic [FLT_W-1:0] pos_x;
    } vertex_t;

endpackage

`default_nettype wire

@@ sv/vertex_dedup_index_remap.sv @@
// Top level: vertex dedup ring, scan control, original-position map and result register.
`default_nettype none

// Vertex words (kind 0) are checked against the unique vertices held in a ring of
// CAP = min(MAX_VERTICES, 256) cells. The ring makes one full turn per vertex, one
// cell per clock past a single comparator at its head; the scan length is set by the
// ring size, not by how many uniques are held. A miss is written into the ring as its
// free slot passes the head. Once the position map is full, a vertex word skips the
// scan. Index words (kind 1) read the 256-entry map of original positions. One word
// is worked on at a time; the next is accepted while the previous result still waits
// in the output register, and a finished word holds until that register is free. A
// vertex word with start_mesh set empties both tables first. No clearing pass after
// reset.

module vertex_dedup_index_remap #(
    parameter int unsigned MAX_VERTICES = vddr_pkg::MAX_VERTICES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pos_x, pos_y, pos_z, nor_x, nor_y, nor_z, tex_u, tex_v, original_index
    input  wire logic [263:0] s_tdata,
    // kind, start_mesh
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // unique_index, is_new, status, unique_total, 4 zero bits
    output logic [23:0]       m_tdata
);
    import vddr_pkg::*;

    localparam int unsigned CAP = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;
    localparam int unsigned SW  = $clog2(CAP);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_WRMAP = 3'd2;
    localparam logic [2:0] S_MAPRD = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // Input word unpack
    vertex_t          s_vtx;
    logic [IDX_W-1:0] s_idx;
    logic             s_kind;
    logic             s_start;

    assign s_vtx   = s_tdata[255:0];
    assign s_idx   = s_tdata[263:256];
    assign s_kind  = s_tuser[0];
    assign s_start = s_tuser[1];

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] loaded_reg;
    logic [CNT_W-1:0] count_eff;
    logic [CNT_W-1:0] loaded_eff;
    logic [SW-1:0]    step_reg;
    logic [CNT_W-1:0] step_ext;
    logic             step_last;
    vertex_t          query_reg;
    logic             found_reg;
    logic             new_reg;
    logic [IDX_W-1:0] uidx_reg;
    logic [1:0]       status_reg;
    logic [IDX_W:0]   map_rd_reg;
    logic [IDX_W:0]   map_mem [MAP_DEPTH];
    logic             m_tvalid_reg;
    logic [23:0]      m_tdata_reg;

    logic             s_accept;
    logic             scanning;
    logic             head_match;
    logic             hit;
    logic             insert;
    logic             out_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign count_eff  = s_start ? '0 : count_reg;
    assign loaded_eff = s_start ? '0 : loaded_reg;
    assign scanning  = (state_reg == S_SCAN);
    assign step_ext  = CNT_W'(step_reg);
    assign step_last = (step_reg == SW'(CAP - 1));
    assign out_free  = !m_tvalid_reg || m_tready;

    // First held unique that matches, or the free slot passing the head on a miss
    assign hit    = scanning && !found_reg && (step_ext < count_reg) && head_match;
    assign insert = scanning && !found_reg && (step_ext == count_reg);

    // Ring of cells; the tail takes the head's vertex, or the new unique
    vertex_t ring [CAP];

    for (genvar i = 0; i < CAP; i++) begin : g_ring
        localparam int unsigned NB = (i == CAP - 1) ? 0 : i + 1;
        vddr_cell u_cell (
            .aclk      (aclk),
            .shift_en  (scanning),
            .load_en   ((i == CAP - 1) ? insert : 1'b0),
            .load_data (query_reg),
            .nb_data   (ring[NB]),
            .cell_data (ring[i])
        );
    end

    vddr_cmp u_cmp (
        .stored (ring[0]),
        .probe  (query_reg),
        .match  (head_match)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    if (s_kind == KIND_VERTEX) begin
                        state_next = loaded_eff[CNT_W-1] ? S_DONE : S_SCAN;
                    end else if ({1'b0, s_idx} >= loaded_reg) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_MAPRD;
                    end
                end
            end
            S_SCAN: begin
                if (step_last) begin
                    state_next = S_WRMAP;
                end
            end
            S_WRMAP: state_next = S_DONE;
            S_MAPRD: state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            loaded_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_accept && (s_kind == KIND_VERTEX)) begin
                count_reg  <= count_eff;
                loaded_reg <= loaded_eff;
            end else if (insert) begin
                count_reg <= count_reg + 1'b1;
            end else if (state_reg == S_WRMAP) begin
                loaded_reg <= loaded_reg + 1'b1;
            end
            if ((state_reg == S_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    query_reg  <= s_vtx;
                    found_reg  <= 1'b0;
                    new_reg    <= 1'b0;
                    uidx_reg   <= '0;
                    step_reg   <= '0;
                    status_reg <= (s_kind == KIND_VERTEX) ? ST_FULL : ST_NOT_LOADED;
                end
            end
            S_SCAN: begin
                step_reg <= step_reg + 1'b1;
                if (hit || insert) begin
                    found_reg <= 1'b1;
                    uidx_reg  <= IDX_W'(step_reg);
                end
                if (insert) begin
                    new_reg <= 1'b1;
                end
            end
            S_WRMAP: begin
                status_reg <= found_reg ? ST_OK : ST_FULL;
            end
            S_MAPRD: begin
                status_reg <= map_rd_reg[IDX_W] ? ST_FULL : ST_OK;
                uidx_reg   <= map_rd_reg[IDX_W-1:0];
            end
            S_DONE: begin
                if (out_free) begin
                    m_tdata_reg <= {4'b0, count_reg, status_reg, new_reg, uidx_reg};
                end
            end
            default: begin
            end
        endcase
    end

    // Original-position map: lost flag over unique number
    always_ff @(posedge aclk) begin
        if (state_reg == S_WRMAP) begin
            map_mem[loaded_reg[IDX_W-1:0]] <= {!found_reg, found_reg ? uidx_reg : '0};
        end
        if (s_accept) begin
            map_rd_reg <= map_mem[s_idx];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The unique count never passes the ring size
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAP))
        else $error("unique count beyond ring capacity");

    // The scan step advances by one each cycle of the ring turn
    a_step_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        scanning && !step_last |=> step_reg == SW'($past(step_reg) + 1'b1))
        else $error("scan step did not advance");

    // A failed result carries unique index zero
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && (m_tdata_reg[10:9] != ST_OK) |-> m_tdata_reg[7:0] == '0)
        else $error("nonzero index on failed result");

    // A new unique is always a successful result
    a_new_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[8] |-> m_tdata_reg[10:9] == ST_OK)
        else $error("new unique with failing status");

endmodule

`default_nettype wire

@@ sv/vddr_cell.sv @@
// One ring cell: holds one unique vertex and passes it to its neighbor on shift.
`default_nettype none

module vddr_cell (
    input  wire logic              aclk,
    input  wire logic              shift_en,
    input  wire logic              load_en,
    input  wire vddr_pkg::vertex_t load_data,
    input  wire vddr_pkg::vertex_t nb_data,
    output vddr_pkg::vertex_t      cell_data
);
    import vddr_pkg::*;

    vertex_t data_reg;

    // Shift in the neighbor's vertex, or a new unique when loading
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            data_reg <= load_en ? load_data : nb_data;
        end
    end

    assign cell_data = data_reg;

endmodule

`default_nettype wire

@@ sv/vddr_cmp.sv @@
// Head comparator: IEEE single equality on all eight fields of two vertices.
`default_nettype none

module vddr_cmp (
    input  wire vddr_pkg::vertex_t stored,
    input  wire vddr_pkg::vertex_t probe,
    output logic                   match
);
    import vddr_pkg::*;

    logic [N_FIELDS-1:0][FLT_W-1:0] stored_f;
    logic [N_FIELDS-1:0][FLT_W-1:0] probe_f;
    logic [N_FIELDS-1:0]            field_eq;

    function automatic logic is_nan(input logic [FLT_W-1:0] a);
        return (&a[30:23]) && (|a[22:0]);
    endfunction

    // +0 equals -0, NaN equals nothing
    function automatic logic flt_eq(input logic [FLT_W-1:0] a, input logic [FLT_W-1:0] b);
        logic [FLT_W-1:0] ab;
        ab = a | b;
        if (is_nan(a) || is_nan(b)) begin
            return 1'b0;
        end
        return (a == b) || (ab[30:0] == '0);
    endfunction

    assign stored_f = stored;
    assign probe_f  = probe;

    // Per-field compares are independent
    always_comb begin
        for (int k = 0; k < N_FIELDS; k++) begin
            field_eq[k] = flt_eq(stored_f[k], probe_f[k]);
        end
    end

    assign match = &field_eq;

endmodule

`default_nettype wire

@@ sim/tb_vertex_dedup_index_remap.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the vertex dedup / index remap stream block.
module tb_vertex_dedup_index_remap;
    import vddr_pkg::*;

    localparam int unsigned CAP         = (MAX_VERTICES_DEF < 256) ? MAX_VERTICES_DEF : 256;
    localparam int unsigned WORD_TARGET = 1900;
    localparam int unsigned IDLE_PCT    = 36;
    localparam int unsigned DRAIN       = CAP + 20;
    localparam longint      CYCLE_LIMIT = 3_000_000;

    // float patterns that stress the equality rules
    localparam logic [31:0] FLT_SPECIALS [10] = '{
        32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000,
        32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001
    };

    typedef struct packed {
        logic       kind;
        logic       start;
        vertex_t    vtx;
        logic [7:0] oidx;
    } remap_word_t;

    // same bit order as m_tdata[19:0]
    typedef struct packed {
        logic [8:0] total;
        logic [1:0] status;
        logic       is_new;
        logic [7:0] uidx;
    } dedup_res_t;

    typedef struct packed {
        remap_word_t w;
        bit          typed;
        dedup_res_t  res;
    } dir_row_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [263:0] s_tdata;   // pos_x, pos_y, pos_z, nor_x, nor_y, nor_z, tex_u, tex_v, original_index
    logic [1:0]   s_tuser;   // kind, start_mesh
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;   // unique_index, is_new, status, unique_total, 4 zero bits

    // predictor state
    logic [31:0]  uniq_tab [CAP][8];
    logic [7:0]   pos_map [MAP_DEPTH];
    bit           pos_lost [MAP_DEPTH];
    int unsigned  uniq_cnt = 0;
    int unsigned  load_cnt = 0;

    dedup_res_t   pending_results [$];
    bit           calm = 1'b0;
    int unsigned  errors = 0;
    int unsigned  words_sent = 0, vtx_words = 0, new_cnt = 0, full_cnt = 0, nl_cnt = 0;
    longint       cycle_cnt = 0;

    vertex_dedup_index_remap DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
                     pending_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // IEEE single equality: NaN never equal, +0 == -0
    function automatic bit flt_eq(input logic [31:0] a, input logic [31:0] b);
        if ((a[30:23] == 8'hFF && a[22:0] != 0) || (b[30:23] == 8'hFF && b[22:0] != 0))
            return 1'b0;
        return (a == b) || (((a | b) & 32'h7FFF_FFFF) == 32'h0);
    endfunction

    // expected answer for one accepted word; updates the tables
    function automatic dedup_res_t dedup_predict(input remap_word_t w);
        dedup_res_t  res;
        logic [31:0] f [8];
        bit          hit, same;
        res = '0;
        hit = 1'b0;
        if (w.kind == KIND_VERTEX) begin
            if (w.start) begin
                uniq_cnt = 0;
                load_cnt = 0;
            end
            for (int k = 0; k < 8; k++) f[k] = w.vtx[32*k +: 32];
            if (load_cnt >= MAP_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                for (int u = 0; u < uniq_cnt; u++) begin
                    if (!hit) begin
                        same = 1'b1;
                        for (int k = 0; k < 8; k++)
                            if (!flt_eq(uniq_tab[u][k], f[k])) same = 1'b0;
                        if (same) begin
                            hit = 1'b1;
                            res.uidx = 8'(u);
                        end
                    end
                end
                // miss: append while there is room
                if (!hit && uniq_cnt < CAP) begin
                    res.uidx = 8'(uniq_cnt);
                    for (int k = 0; k < 8; k++) uniq_tab[uniq_cnt][k] = f[k];
                    uniq_cnt++;
                    res.is_new = 1'b1;
                    hit = 1'b1;
                end
                pos_lost[load_cnt] = !hit;
                pos_map[load_cnt]  = hit ? res.uidx : 8'd0;
                if (!hit) begin
                    res.status = ST_FULL;
                    res.uidx   = 8'd0;
                end
                load_cnt++;
            end
        end else begin
            if (w.oidx >= load_cnt)
                res.status = ST_NOT_LOADED;
            else if (pos_lost[w.oidx])
                res.status = ST_FULL;
            else
                res.uidx = pos_map[w.oidx];
        end
        res.total = 9'(uniq_cnt);
        return res;
    endfunction

    function automatic logic [31:0] rand_float();
        if ($urandom_range(1) == 1) return FLT_SPECIALS[$urandom_range(9)];
        return $urandom;
    endfunction

    function automatic vertex_t rand_vertex();
        vertex_t v;
        for (int k = 0; k < 8; k++) v[32*k +: 32] = rand_float();
        return v;
    endfunction

    function automatic dir_row_t mk_row(input logic kind, input logic start,
                                        input vertex_t vtx, input logic [7:0] oidx,
                                        input bit typed, input logic [7:0] e_uidx,
                                        input logic e_new, input logic [1:0] e_st,
                                        input logic [8:0] e_tot);
        dir_row_t r;
        r.w     = '{kind, start, vtx, oidx};
        r.typed = typed;
        r.res   = '{e_tot, e_st, e_new, e_uidx};
        return r;
    endfunction

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 10) $display("[%0t] %s", $time, msg);
    endtask

    // drive one word at the falling edge, hold it until accepted
    task automatic send_word(input remap_word_t w, input bit typed, input dedup_res_t fixed);
        dedup_res_t res;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w.oidx, w.vtx};
        s_tuser  <= {w.start, w.kind};
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        res = dedup_predict(w);
        pending_results.push_back(typed ? fixed : res);
        words_sent++;
        if (w.kind == KIND_VERTEX) vtx_words++;
        if (res.is_new) new_cnt++;
        if (res.status == ST_FULL) full_cnt++;
        if (res.status == ST_NOT_LOADED) nl_cnt++;
        @(negedge aclk);
    endtask

    // result side back-pressure
    always @(negedge aclk) m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // result checker
    always @(posedge aclk) begin
        dedup_res_t want, got;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready) begin
            got = m_tdata[19:0];
            if (pending_results.size() == 0) begin
                note_error($sformatf("result word %h with nothing pending", m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (got.uidx !== want.uidx || got.is_new !== want.is_new ||
                    got.status !== want.status || got.total !== want.total ||
                    m_tdata[23:20] !== 4'h0)
                    note_error($sformatf(
                        "exp idx=%0d new=%0d st=%0d tot=%0d, got idx=%0d new=%0d st=%0d tot=%0d pad=%h",
                        want.uidx, want.is_new, want.status, want.total,
                        got.uidx, got.is_new, got.status, got.total, m_tdata[23:20]));
            end
        end
    end

    initial begin
        dir_row_t    dir_rows [$];
        vertex_t     pool [$];
        vertex_t     v;
        remap_word_t w;
        int unsigned mesh_len, r, j, span;
        bit          fresh_mesh;
        logic [7:0]  oidx;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed rows: kind, start, vertex, index, typed, idx, new, status, total
        dir_rows.push_back(mk_row(KIND_INDEX, 1'b0, '0, 8'd0, 1, 8'd0, 1'b0, ST_NOT_LOADED, 9'd0));
        dir_rows.push_back(mk_row(KIND_INDEX, 1'b1, '1, 8'd255, 1, 8'd0, 1'b0, ST_NOT_LOADED, 9'd0));
        dir_rows.push_back(mk_row(KIND_VERTEX, 1'b1, {8{32'h0000_0000}}, 8'd0,
                                  1, 8'd0, 1'b1, ST_OK, 9'd1));
        // negative zero matches positive zero
        dir_rows.push_back(mk_row(KIND_VERTEX, 1'b0, {8{32'h8000_0000}}, 8'd0,
                                  1, 8'd0, 1'b0, ST_OK, 9'd1));
        dir_rows.push_back(mk_row(KIND_VERTEX, 1'b0, {8{32'h7F80_0000}}, 8'd255,
                                  1, 8'd1, 1'b1, ST_OK, 9'd2));
        dir_rows.push_back(mk_row(KIND_VERTEX, 1'b0, {8{32'hFF80_0000}}, 8'd0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(KIND_VERTEX, 1'b0, {8{32'h7F80_0000}}, 8'd0, 0, 0, 0, 0, 0));
        // NaN never matches, not even an identical pattern
        dir_rows.push_back(mk_row(KIND_VERTEX, 1'b0, {8{32'hFFFF_FFFF}}, 8'd0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(KIND_VERTEX, 1'b0, {8{32'hFFFF_FFFF}}, 8'd0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(KIND_VERTEX, 1'b0, {32'h7FC0_0000, {7{32'h0}}}, 8'd0,
                                  0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(KIND_VERTEX, 1'b0, {4{32'h0000_0000, 32'h8000_0000}}, 8'd0,
                                  0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(KIND_VERTEX, 1'b0, {8{32'h0000_0001}}, 8'd0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(KIND_VERTEX, 1'b0, {8{32'h7FFF_FFFF}}, 8'd0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(KIND_INDEX, 1'b0, '0, 8'd0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(KIND_INDEX, 1'b0, '0, 8'd1, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(KIND_INDEX, 1'b0, '0, 8'd3, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(KIND_INDEX, 1'b0, '0, 8'd4, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(KIND_INDEX, 1'b0, '0, 8'd10, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(KIND_INDEX, 1'b0, '0, 8'd11, 1, 8'd0, 1'b0, ST_NOT_LOADED, 9'd8));
        // new mesh clears both tables
        dir_rows.push_back(mk_row(KIND_VERTEX, 1'b1, {8{32'h3F80_0000}}, 8'd0,
                                  1, 8'd0, 1'b1, ST_OK, 9'd1));
        dir_rows.push_back(mk_row(KIND_INDEX, 1'b0, '0, 8'd1, 1, 8'd0, 1'b0, ST_NOT_LOADED, 9'd1));
        dir_rows.push_back(mk_row(KIND_VERTEX, 1'b0, {{7{32'h3F80_0000}}, 32'hBF80_0000}, 8'd0,
                                  0, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(KIND_VERTEX, 1'b1, {8{32'h7F80_0001}}, 8'd0,
                                  1, 8'd0, 1'b1, ST_OK, 9'd1));
        dir_rows.push_back(mk_row(KIND_INDEX, 1'b1, '0, 8'd0, 0, 0, 0, 0, 0));

        foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);

        // sender holds off until all results are back
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        @(negedge aclk);

        // fill a mesh to capacity, then overflow the position map; no idling here
        calm = 1'b1;
        for (int k = 0; k < MAP_DEPTH + 3; k++) begin
            v       = rand_vertex();
            v.pos_x = 32'h3F80_0000 + k;
            w       = '{KIND_VERTEX, (k == 0), v, 8'($urandom)};
            send_word(w, 1'b0, '0);
        end
        for (int k = 0; k < 16; k++) begin
            w = '{KIND_INDEX, 1'($urandom), rand_vertex(), 8'($urandom)};
            send_word(w, 1'b0, '0);
        end
        calm = 1'b0;

        // random meshes: fresh vertices, near repeats and lookups
        while (words_sent < WORD_TARGET) begin
            mesh_len   = $urandom_range(40, 4);
            fresh_mesh = ($urandom_range(7) != 0);
            if (fresh_mesh) pool.delete();
            for (int n = 0; n < mesh_len; n++) begin
                r = $urandom_range(99);
                if (n == 0 || r < 45) begin
                    if (pool.size() != 0 && $urandom_range(99) < 45) begin
                        v = pool[$urandom_range(pool.size() - 1)];
                        // flip signs of zero fields; still a match
                        for (int k = 0; k < 8; k++)
                            if (v[32*k +: 31] == 31'h0 && $urandom_range(1) == 1)
                                v[32*k + 31] = ~v[32*k + 31];
                        // sometimes disturb one field
                        if ($urandom_range(3) == 0) begin
                            j = $urandom_range(7);
                            v[32*j +: 32] = rand_float();
                        end
                    end else begin
                        v = rand_vertex();
                    end
                    pool.push_back(v);
                    w = '{KIND_VERTEX, (n == 0) && fresh_mesh, v, 8'($urandom)};
                end else begin
                    span = (load_cnt > MAP_DEPTH) ? MAP_DEPTH : load_cnt;
                    if (span != 0 && r < 88)
                        oidx = 8'($urandom_range(span - 1));
                    else
                        oidx = 8'($urandom);
                    w = '{KIND_INDEX, 1'($urandom), rand_vertex(), oidx};
                end
                send_word(w, 1'b0, '0);
            end
        end

        // drain
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        $display("Run: %0d words, %0d vertices, %0d lookups, %0d new uniques", words_sent,
                 vtx_words, words_sent - vtx_words, new_cnt);
        $display("Run: %0d full answers, %0d not-loaded answers, %0d errors", full_cnt,
                 nl_cnt, errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
